@@ src/grid_path_turn_point_compressor_defines.svh @@
// assertion macros for the grid path turn point compressor
`ifndef GRID_PATH_TURN_POINT_COMPRESSOR_DEFINES_SVH
`define GRID_PATH_TURN_POINT_COMPRESSOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GPTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gptc check failed");
`define GPTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gptc check failed");
`else
`define GPTC_ASSERT_IMP(lbl, ante, cons)
`define GPTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ src/gptc_pkg.sv @@
// shared types and constants of the grid path turn point compressor
package gptc_pkg;

  localparam int COORD_W = 16;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [2:0] DIR_UNKNOWN = 3'd0;
  localparam logic [2:0] DIR_VERT    = 3'd1;
  localparam logic [2:0] DIR_HORZ    = 3'd2;
  localparam logic [2:0] DIR_SE      = 3'd3;
  localparam logic [2:0] DIR_SW      = 3'd4;
  localparam logic [2:0] DIR_NE      = 3'd5;
  localparam logic [2:0] DIR_NW      = 3'd6;
  localparam logic [2:0] STEP_STILL  = 3'd7;

  typedef logic [COORD_W-1:0] coord_t;

  // one accepted point worth of results: first beat, optional end beat
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    logic   a_end;
    logic   two;
    coord_t b_x;
    coord_t b_y;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   avail;
    logic   full;
    entry_t entry;
  } head_t;

endpackage

@@ src/gptc_front.sv @@
// front part: step classification, run tracking and result planning
module gptc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  gptc_pkg::coord_t        point_x,
  input  gptc_pkg::coord_t        point_y,
  input  logic                    final_point,
  output gptc_pkg::push_t         wr
);

  localparam int CW = (COORD_BITS < gptc_pkg::COORD_W) ? COORD_BITS : gptc_pkg::COORD_W;

  logic [CW-1:0] prev_x_r, prev_y_r;
  logic [CW-1:0] x, y;
  logic [2:0]    run_r, run_nxt;
  logic          mid_r, mid_nxt;
  logic [2:0]    step, step_run, run_cur;
  logic          turn;

  assign x = point_x[CW-1:0];
  assign y = point_y[CW-1:0];

  always_comb begin
    if (x == prev_x_r) begin
      step = (y == prev_y_r) ? gptc_pkg::STEP_STILL : gptc_pkg::DIR_VERT;
    end else if (y == prev_y_r) begin
      step = gptc_pkg::DIR_HORZ;
    end else if (y > prev_y_r) begin
      step = (x > prev_x_r) ? gptc_pkg::DIR_SE : gptc_pkg::DIR_SW;
    end else begin
      step = (x > prev_x_r) ? gptc_pkg::DIR_NE : gptc_pkg::DIR_NW;
    end
  end

  assign step_run = (step == gptc_pkg::STEP_STILL) ? gptc_pkg::DIR_VERT : step;
  assign run_cur  = (run_r == gptc_pkg::DIR_UNKNOWN) ? step_run : run_r;
  assign turn     = (step != run_cur);

  always_comb begin
    wr.push        = 1'b0;
    wr.entry.a_x   = gptc_pkg::coord_t'(x);
    wr.entry.a_y   = gptc_pkg::coord_t'(y);
    wr.entry.a_end = final_point;
    wr.entry.two   = 1'b0;
    wr.entry.b_x   = gptc_pkg::coord_t'(x);
    wr.entry.b_y   = gptc_pkg::coord_t'(y);
    run_nxt        = run_r;
    mid_nxt        = mid_r;
    if (acc) begin
      if (!mid_r) begin
        wr.push = 1'b1;
        run_nxt = gptc_pkg::DIR_UNKNOWN;
        mid_nxt = !final_point;
      end else begin
        wr.push = turn || final_point;
        run_nxt = turn ? step_run : run_cur;
        if (turn) begin
          wr.entry.a_x   = gptc_pkg::coord_t'(prev_x_r);
          wr.entry.a_y   = gptc_pkg::coord_t'(prev_y_r);
          wr.entry.a_end = 1'b0;
          wr.entry.two   = final_point;
        end
        if (final_point) begin
          run_nxt = gptc_pkg::DIR_UNKNOWN;
          mid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r <= '0;
      prev_y_r <= '0;
      run_r    <= gptc_pkg::DIR_UNKNOWN;
      mid_r    <= 1'b0;
    end else begin
      if (acc) begin
        prev_x_r <= x;
        prev_y_r <= y;
      end
      run_r <= run_nxt;
      mid_r <= mid_nxt;
    end
  end

endmodule

@@ src/gptc_queue.sv @@
// short queue of planned results between front and back
module gptc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  gptc_pkg::push_t wr,
  input  logic            pop,
  output gptc_pkg::head_t hd
);

  gptc_pkg::entry_t                 mem_r [gptc_pkg::QDEPTH];
  logic [gptc_pkg::QPTR_W-1:0]      wp_r, rp_r;
  logic [gptc_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !wr.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign hd.avail = (cnt_r != '0);
  assign hd.full  = (cnt_r == gptc_pkg::QCNT_W'(gptc_pkg::QDEPTH));
  assign hd.entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wp_r] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr.push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/gptc_back.sv @@
// back part: splits planned results into beats behind an output register
module gptc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gptc_pkg::head_t         hd,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output gptc_pkg::coord_t        out_kept_x,
  output gptc_pkg::coord_t        out_kept_y,
  output logic                    out_path_end
);

  logic             valid_r;
  logic             phase_r, phase_nxt;
  logic             load, emit;
  gptc_pkg::coord_t x_r, y_r;
  logic             end_r;

  assign load = !valid_r || !out_stall;
  assign emit = load && hd.avail;
  assign pop  = emit && (!hd.entry.two || phase_r);

  always_comb begin
    phase_nxt = phase_r;
    if (emit) begin
      phase_nxt = hd.entry.two && !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= hd.avail;
      end
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (phase_r) begin
        x_r   <= hd.entry.b_x;
        y_r   <= hd.entry.b_y;
        end_r <= 1'b1;
      end else begin
        x_r   <= hd.entry.a_x;
        y_r   <= hd.entry.a_y;
        end_r <= hd.entry.a_end;
      end
    end
  end

  assign out_valid    = valid_r;
  assign out_kept_x   = x_r;
  assign out_kept_y   = y_r;
  assign out_path_end = end_r;

endmodule

@@ src/grid_path_turn_point_compressor.sv @@
// top level: grid path turn point compressor
// a kept point passes through the queue and then the output register
// throughput: one point beat a cycle in, one result beat a cycle out, unless stalled;
//   a point with turn and end gives two beats; a four-entry queue absorbs the difference
// reset: synchronous active-low rst_n clears run state, queue and output valid
`include "grid_path_turn_point_compressor_defines.svh"
module grid_path_turn_point_compressor #(
  parameter int COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  gptc_pkg::coord_t in_point_x,
  input  gptc_pkg::coord_t in_point_y,
  input  logic             in_final_point,
  output logic             out_valid,
  input  logic             out_stall,
  output gptc_pkg::coord_t out_kept_x,
  output gptc_pkg::coord_t out_kept_y,
  output logic             out_path_end
);

  gptc_pkg::push_t wr;
  gptc_pkg::head_t hd;
  logic            acc;
  logic            pop;

  assign in_stall = hd.full;
  assign acc      = in_valid && !in_stall;

  gptc_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .point_x    (in_point_x),
    .point_y    (in_point_y),
    .final_point(in_final_point),
    .wr         (wr)
  );

  gptc_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (wr),
    .pop  (pop),
    .hd   (hd)
  );

  gptc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .hd          (hd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kept_x  (out_kept_x),
    .out_kept_y  (out_kept_y),
    .out_path_end(out_path_end)
  );

  `GPTC_ASSERT_IMP(a_no_push_when_full, hd.full, !wr.push)
  `GPTC_ASSERT_IMP(a_no_pop_when_empty, pop, hd.avail)
  `GPTC_ASSERT_NEXT(a_pop_fills_output, pop, out_valid)

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench of the grid path turn point compressor, with a turn point scoreboard
module tb_top;
  import gptc_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } kept_t;

  class turn_point_board;
    kept_t      expected_kept[$];
    int         fails;
    coord_t     prev_x;
    coord_t     prev_y;
    logic [2:0] run_dir;
    logic       mid_path;

    function new();
      fails    = 0;
      prev_x   = '0;
      prev_y   = '0;
      run_dir  = DIR_UNKNOWN;
      mid_path = 1'b0;
    endfunction

    task report(input string msg);
      fails++;
      $display("mismatch: %s", msg);
    endtask

    function logic [2:0] step_dir(input coord_t ax, ay, bx, by);
      if (ax == bx) return (ay == by) ? STEP_STILL : DIR_VERT;
      if (ay == by) return DIR_HORZ;
      if (by > ay) return (bx > ax) ? DIR_SE : DIR_SW;
      return (bx > ax) ? DIR_NE : DIR_NW;
    endfunction

    function void keep(input coord_t x, y, input logic last);
      kept_t k;
      k.x = x;
      k.y = y;
      k.last = last;
      expected_kept.push_back(k);
    endfunction

    // accepted point beat
    function void note_point(input coord_t x, y, input logic fin);
      logic [2:0] step;
      if (!mid_path) begin
        keep(x, y, fin);
        run_dir  = DIR_UNKNOWN;
        mid_path = !fin;
      end else begin
        step = step_dir(prev_x, prev_y, x, y);
        if (run_dir == DIR_UNKNOWN) run_dir = (step == STEP_STILL) ? DIR_VERT : step;
        if (step != run_dir) begin
          keep(prev_x, prev_y, 1'b0);
          run_dir = (step == STEP_STILL) ? DIR_VERT : step;
        end
        if (fin) begin
          keep(x, y, 1'b1);
          run_dir  = DIR_UNKNOWN;
          mid_path = 1'b0;
        end
      end
      prev_x = x;
      prev_y = y;
    endfunction

    // accepted result beat
    task check_kept(input coord_t x, y, input logic last);
      kept_t k;
      if (expected_kept.size() == 0) begin
        report($sformatf("unexpected kept point x=%h y=%h end=%b", x, y, last));
      end else begin
        k = expected_kept.pop_front();
        if (x !== k.x) report($sformatf("kept_x %h, want %h", x, k.x));
        if (y !== k.y) report($sformatf("kept_y %h, want %h", y, k.y));
        if (last !== k.last) report($sformatf("path_end %b, want %b", last, k.last));
      end
    endtask

    task check_drained();
      if (expected_kept.size() != 0)
        report($sformatf("%0d kept points never arrived", expected_kept.size()));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic   in_final_point = 1'b0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  coord_t out_kept_x;
  coord_t out_kept_y;
  logic   out_path_end;

  turn_point_board board;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int points_sent = 0;
  localparam int QUIET_FROM = 550;

  grid_path_turn_point_compressor #(.COORD_BITS(16)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .in_final_point(in_final_point),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kept_x(out_kept_x),
    .out_kept_y(out_kept_y),
    .out_path_end(out_path_end)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #600000;
    $display("CHECKS FAILED");
    $finish;
  end

  // result side: check, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_kept(out_kept_x, out_kept_y, out_path_end);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = 120;
      out_stall <= 1'b1;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task send_point(input coord_t x, y, input logic fin);
    int gap;
    if (points_sent >= QUIET_FROM) begin
      tx_idle = 1'b0;
      rx_idle = 1'b0;
    end
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_point_x     <= x;
    in_point_y     <= y;
    in_final_point <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_point(x, y, fin);
    points_sent++;
  endtask

  // mostly runs of small steps with random turns, some paths of scattered points
  task send_random_paths(input int n);
    int left, len, k, dx, dy, mag;
    bit scatter;
    coord_t x, y;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 14);
      if (len > left) len = left;
      scatter = ($urandom_range(0, 9) == 0);
      x = coord_t'($urandom);
      y = coord_t'($urandom);
      dx = int'($urandom_range(0, 2)) - 1;
      dy = int'($urandom_range(0, 2)) - 1;
      for (k = 0; k < len; k++) begin
        if (k > 0) begin
          if (scatter) begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
          end else if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 3) == 0) begin
              dx = int'($urandom_range(0, 4)) - 2;
              dy = int'($urandom_range(0, 4)) - 2;
            end
            mag = $urandom_range(1, 3);
            x = x + coord_t'(dx * mag);
            y = y + coord_t'(dy * mag);
          end
        end
        send_point(x, y, k == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    int waited;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // single point paths at the extremes
    send_point(16'h0000, 16'h0000, 1'b1);
    send_point(16'hffff, 16'hffff, 1'b1);
    // zero-length steps, first point kept twice
    send_point(16'h0005, 16'h0005, 1'b0);
    send_point(16'h0005, 16'h0005, 1'b0);
    send_point(16'h0005, 16'h0006, 1'b1);
    // straight vertical run
    send_point(16'h000a, 16'h0000, 1'b0);
    send_point(16'h000a, 16'h0001, 1'b0);
    send_point(16'h000a, 16'h0002, 1'b0);
    send_point(16'h000a, 16'h0003, 1'b1);
    // back-to-back turns through every direction but vertical
    send_point(16'h0000, 16'h0000, 1'b0);
    send_point(16'h0001, 16'h0000, 1'b0);
    send_point(16'h0002, 16'h0001, 1'b0);
    send_point(16'h0001, 16'h0002, 1'b0);
    send_point(16'h0002, 16'h0001, 1'b0);
    send_point(16'h0001, 16'h0000, 1'b0);
    send_point(16'h0001, 16'h0000, 1'b0);
    send_point(16'hffff, 16'h0000, 1'b0);
    send_point(16'h0000, 16'hffff, 1'b1);
    // alternating bit patterns
    send_point(16'haaaa, 16'h5555, 1'b0);
    send_point(16'h5555, 16'haaaa, 1'b1);

    // long receiver hold-off while points keep coming
    hold_req = 1'b1;
    send_random_paths(630);
    in_valid <= 1'b0;

    waited = 0;
    while (board.expected_kept.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    board.check_drained();
    if (board.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/gptc_pkg.sv
src/gptc_front.sv
src/gptc_queue.sv
src/gptc_back.sv
src/grid_path_turn_point_compressor.sv
tb/sv/tb_top.sv
